@@ rtl/core/via_tmr_pkg.sv @@
// ----------------------------------------------------------------------------
// via_tmr_pkg
// Shared types and constants for the VIA-style timer and register block.
// ----------------------------------------------------------------------------
package via_tmr_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    // register window
    localparam logic [3:0] REG_PORT_B  = 4'd0;
    localparam logic [3:0] REG_PORT_A  = 4'd1;
    localparam logic [3:0] REG_DIR_B   = 4'd2;
    localparam logic [3:0] REG_DIR_A   = 4'd3;
    localparam logic [3:0] REG_T1_LO   = 4'd4;
    localparam logic [3:0] REG_T1_HI   = 4'd5;
    localparam logic [3:0] REG_T1L_LO  = 4'd6;
    localparam logic [3:0] REG_T1L_HI  = 4'd7;
    localparam logic [3:0] REG_T2_LO   = 4'd8;
    localparam logic [3:0] REG_T2_HI   = 4'd9;
    localparam logic [3:0] REG_SHIFT   = 4'd10;
    localparam logic [3:0] REG_AUX     = 4'd11;
    localparam logic [3:0] REG_PERIPH  = 4'd12;
    localparam logic [3:0] REG_IFR     = 4'd13;
    localparam logic [3:0] REG_IER     = 4'd14;

    localparam int FLAG_T1_BIT = 6;
    localparam int FLAG_T2_BIT = 5;
    localparam int IER_SET_BIT = 7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  reg_offset;
        logic [7:0]  write_data;
        logic [15:0] tick_count;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
    } result_t;

endpackage

@@ rtl/core/via_timer_register_block_top.sv @@
// ----------------------------------------------------------------------------
// via_timer_register_block_top
// VIA-style register window with two 16-bit down timers and interrupt logic.
// ----------------------------------------------------------------------------
// Each accepted word (read, write or tick) yields exactly one result word.
// The block sustains one word per clock while results are taken: a word is
// captured in an input register, and from there it updates the register file
// and timers and loads its result into the result register, where the result
// word is valid. Throughput is set by the register/timer update between the
// input register and the result register; a stalled result holds the pipeline
// only once both registers are full.
module via_timer_register_block_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  reg_offset,
    input  logic [7:0]  write_data,
    input  logic [15:0] tick_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        irq_out
);

    logic                  s1_valid_reg, s1_valid_next;
    via_tmr_pkg::item_t    s1_item_reg;
    logic                  out_valid_reg, out_valid_next;
    via_tmr_pkg::result_t  out_res_reg;
    via_tmr_pkg::result_t  res;
    logic                  advance;
    logic                  fire;
    logic                  in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    via_tmr_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s1_item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= '{req_type:   req_type,
                             reg_offset: reg_offset,
                             write_data: write_data,
                             tick_count: tick_count};
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_res_reg.read_data;
    assign irq_out   = out_res_reg.irq_out;

`ifndef SYNTHESIS
    a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s1_item_reg.req_type != via_tmr_pkg::REQ_TICK) |=> !irq_out)
        else $error("irq set on a non-tick word");

    a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s1_item_reg.req_type != via_tmr_pkg::REQ_READ) |=> read_data == 8'd0)
        else $error("read data nonzero on a non-read word");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg)
        else $error("input word dropped while stalled");
`endif

endmodule

@@ rtl/core/via_tmr_regs.sv @@
// ----------------------------------------------------------------------------
// via_tmr_regs
// Register file, timers and interrupt logic; processes one word per fire.
// ----------------------------------------------------------------------------
module via_tmr_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  via_tmr_pkg::item_t   item,
    output via_tmr_pkg::result_t res
);

    logic [7:0]  port_b_reg,  port_b_next;
    logic [7:0]  port_a_reg,  port_a_next;
    logic [7:0]  dir_b_reg,   dir_b_next;
    logic [7:0]  dir_a_reg,   dir_a_next;
    logic [15:0] t1_cnt_reg,  t1_cnt_next;
    logic [15:0] t1_rld_reg,  t1_rld_next;
    logic [15:0] t2_cnt_reg,  t2_cnt_next;
    logic [15:0] t2_rld_reg,  t2_rld_next;
    logic [7:0]  shift_reg_q, shift_next;
    logic [7:0]  aux_reg,     aux_next;
    logic [7:0]  periph_reg,  periph_next;
    logic [7:0]  ifr_reg,     ifr_next;
    logic [6:0]  ier_reg,     ier_next;
    logic [7:0]  rd_mux;

    // read selection
    always_comb
    begin
        case (item.reg_offset)
            via_tmr_pkg::REG_PORT_B:  rd_mux = port_b_reg;
            via_tmr_pkg::REG_PORT_A:  rd_mux = port_a_reg;
            via_tmr_pkg::REG_DIR_B:   rd_mux = dir_b_reg;
            via_tmr_pkg::REG_DIR_A:   rd_mux = dir_a_reg;
            via_tmr_pkg::REG_T1_LO:   rd_mux = t1_cnt_reg[7:0];
            via_tmr_pkg::REG_T1_HI:   rd_mux = t1_cnt_reg[15:8];
            via_tmr_pkg::REG_T1L_LO:  rd_mux = t1_rld_reg[7:0];
            via_tmr_pkg::REG_T1L_HI:  rd_mux = t1_rld_reg[15:8];
            via_tmr_pkg::REG_T2_LO:   rd_mux = t2_cnt_reg[7:0];
            via_tmr_pkg::REG_T2_HI:   rd_mux = t2_cnt_reg[15:8];
            via_tmr_pkg::REG_SHIFT:   rd_mux = shift_reg_q;
            via_tmr_pkg::REG_AUX:     rd_mux = aux_reg;
            via_tmr_pkg::REG_PERIPH:  rd_mux = periph_reg;
            via_tmr_pkg::REG_IFR:     rd_mux = ifr_reg;
            via_tmr_pkg::REG_IER:     rd_mux = {1'b1, ier_reg};
            default:                  rd_mux = port_a_reg;   // offset 15 mirrors port A
        endcase
    end

    always_comb
    begin
        port_b_next = port_b_reg;
        port_a_next = port_a_reg;
        dir_b_next  = dir_b_reg;
        dir_a_next  = dir_a_reg;
        t1_cnt_next = t1_cnt_reg;
        t1_rld_next = t1_rld_reg;
        t2_cnt_next = t2_cnt_reg;
        t2_rld_next = t2_rld_reg;
        shift_next  = shift_reg_q;
        aux_next    = aux_reg;
        periph_next = periph_reg;
        ifr_next    = ifr_reg;
        ier_next    = ier_reg;
        res         = '0;

        case (via_tmr_pkg::req_t'(item.req_type))
            via_tmr_pkg::REQ_READ:
            begin
                res.read_data = rd_mux;
                if (item.reg_offset == via_tmr_pkg::REG_T1_HI)
                begin
                    ifr_next[via_tmr_pkg::FLAG_T1_BIT] = 1'b0;
                end
            end
            via_tmr_pkg::REQ_WRITE:
            begin
                case (item.reg_offset)
                    via_tmr_pkg::REG_PORT_B:  port_b_next = item.write_data;
                    via_tmr_pkg::REG_PORT_A:  port_a_next = item.write_data;
                    via_tmr_pkg::REG_DIR_B:   dir_b_next  = item.write_data;
                    via_tmr_pkg::REG_DIR_A:   dir_a_next  = item.write_data;
                    via_tmr_pkg::REG_T1_LO,
                    via_tmr_pkg::REG_T1L_LO:  t1_rld_next = {t1_rld_reg[15:8], item.write_data};
                    via_tmr_pkg::REG_T1_HI:
                    begin
                        t1_rld_next = {item.write_data, t1_rld_reg[7:0]};
                        t1_cnt_next = {item.write_data, t1_rld_reg[7:0]};
                        ifr_next[via_tmr_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    via_tmr_pkg::REG_T1L_HI:  t1_rld_next = {item.write_data, t1_rld_reg[7:0]};
                    via_tmr_pkg::REG_T2_LO:   t2_rld_next = {t2_rld_reg[15:8], item.write_data};
                    via_tmr_pkg::REG_T2_HI:   t2_cnt_next = {item.write_data, t2_rld_reg[7:0]};
                    via_tmr_pkg::REG_SHIFT:   shift_next  = item.write_data;
                    via_tmr_pkg::REG_AUX:     aux_next    = item.write_data;
                    via_tmr_pkg::REG_PERIPH:  periph_next = item.write_data;
                    via_tmr_pkg::REG_IFR:     ifr_next    = item.write_data;
                    via_tmr_pkg::REG_IER:
                    begin
                        if (item.write_data[via_tmr_pkg::IER_SET_BIT])
                        begin
                            ier_next = ier_reg | item.write_data[6:0];
                        end
                        else
                        begin
                            ier_next = ier_reg & ~item.write_data[6:0];
                        end
                    end
                    default:                  port_a_next = item.write_data;
                endcase
            end
            via_tmr_pkg::REQ_TICK:
            begin
                // flag when the counter reaches or passes zero during this tick
                if (t1_cnt_reg <= item.tick_count)
                begin
                    ifr_next[via_tmr_pkg::FLAG_T1_BIT] = 1'b1;
                end
                if (t2_cnt_reg <= item.tick_count)
                begin
                    ifr_next[via_tmr_pkg::FLAG_T2_BIT] = 1'b1;
                end
                t1_cnt_next = t1_cnt_reg - item.tick_count;
                t2_cnt_next = t2_cnt_reg - item.tick_count;
                res.irq_out =
                    (ifr_next[via_tmr_pkg::FLAG_T1_BIT] & ier_reg[via_tmr_pkg::FLAG_T1_BIT]) |
                    (ifr_next[via_tmr_pkg::FLAG_T2_BIT] & ier_reg[via_tmr_pkg::FLAG_T2_BIT]);
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_b_reg  <= '0;
            port_a_reg  <= '0;
            dir_b_reg   <= '0;
            dir_a_reg   <= '0;
            t1_cnt_reg  <= '0;
            t1_rld_reg  <= '0;
            t2_cnt_reg  <= '0;
            t2_rld_reg  <= '0;
            shift_reg_q <= '0;
            aux_reg     <= '0;
            periph_reg  <= '0;
            ifr_reg     <= '0;
            ier_reg     <= '0;
        end
        else if (fire)
        begin
            port_b_reg  <= port_b_next;
            port_a_reg  <= port_a_next;
            dir_b_reg   <= dir_b_next;
            dir_a_reg   <= dir_a_next;
            t1_cnt_reg  <= t1_cnt_next;
            t1_rld_reg  <= t1_rld_next;
            t2_cnt_reg  <= t2_cnt_next;
            t2_rld_reg  <= t2_rld_next;
            shift_reg_q <= shift_next;
            aux_reg     <= aux_next;
            periph_reg  <= periph_next;
            ifr_reg     <= ifr_next;
            ier_reg     <= ier_next;
        end
    end

endmodule

@@ tb/via_timer_register_block_checker.sv @@
// ----------------------------------------------------------------------------
// via_timer_register_block_checker
// Watches both channels of the VIA timer/register block. Every accepted
// request word is run through a local model of the register file and timers.
// The predicted result goes into a queue. Every accepted result word is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module via_timer_register_block_checker
    import via_tmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  reg_offset,
    input  logic [7:0]  write_data,
    input  logic [15:0] tick_count,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        irq_out,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // local copy of the register file
    logic [7:0]  port_b;
    logic [7:0]  port_a;
    logic [7:0]  ddr_b;
    logic [7:0]  ddr_a;
    logic [15:0] t1_count;
    logic [15:0] t1_latch;
    logic [15:0] t2_count;
    logic [15:0] t2_latch;
    logic [7:0]  shift_val;
    logic [7:0]  acr;
    logic [7:0]  pcr;
    logic [7:0]  ifr;
    logic [6:0]  ier;

    result_t     expected_results[$];
    result_t     predicted;
    result_t     oldest;
    int          mismatch_count = 0;
    int          expected_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = expected_count;

    // Apply one bus word to the register model and return its result word.
    task automatic bus_access(input logic [1:0] kind, input logic [3:0] idx,
                              input logic [7:0] data, input logic [15:0] ticks,
                              output result_t res);
        res = '0;
        case (kind)
            REQ_READ:
            begin
                case (idx)
                    REG_PORT_B: res.read_data = port_b;
                    REG_PORT_A: res.read_data = port_a;
                    REG_DIR_B:  res.read_data = ddr_b;
                    REG_DIR_A:  res.read_data = ddr_a;
                    REG_T1_LO:  res.read_data = t1_count[7:0];
                    REG_T1_HI:
                    begin
                        res.read_data      = t1_count[15:8];
                        ifr[FLAG_T1_BIT]   = 1'b0;
                    end
                    REG_T1L_LO: res.read_data = t1_latch[7:0];
                    REG_T1L_HI: res.read_data = t1_latch[15:8];
                    REG_T2_LO:  res.read_data = t2_count[7:0];
                    REG_T2_HI:  res.read_data = t2_count[15:8];
                    REG_SHIFT:  res.read_data = shift_val;
                    REG_AUX:    res.read_data = acr;
                    REG_PERIPH: res.read_data = pcr;
                    REG_IFR:    res.read_data = ifr;
                    REG_IER:    res.read_data = {1'b1, ier};
                    default:    res.read_data = port_a;  // top slot mirrors port A
                endcase
            end
            REQ_WRITE:
            begin
                case (idx)
                    REG_PORT_B: port_b = data;
                    REG_PORT_A: port_a = data;
                    REG_DIR_B:  ddr_b  = data;
                    REG_DIR_A:  ddr_a  = data;
                    REG_T1_LO,
                    REG_T1L_LO: t1_latch[7:0] = data;
                    REG_T1_HI:
                    begin
                        t1_latch[15:8]   = data;
                        t1_count         = t1_latch;
                        ifr[FLAG_T1_BIT] = 1'b0;
                    end
                    REG_T1L_HI: t1_latch[15:8] = data;
                    REG_T2_LO:  t2_latch[7:0]  = data;
                    REG_T2_HI:  t2_count = {data, t2_latch[7:0]};
                    REG_SHIFT:  shift_val = data;
                    REG_AUX:    acr = data;
                    REG_PERIPH: pcr = data;
                    REG_IFR:    ifr = data;
                    REG_IER:
                    begin
                        if (data[IER_SET_BIT])
                            ier = ier | data[6:0];
                        else
                            ier = ier & ~data[6:0];
                    end
                    default:    port_a = data;
                endcase
            end
            REQ_TICK:
            begin
                // flag compares against the count before the subtraction
                if (t1_count <= ticks)
                    ifr[FLAG_T1_BIT] = 1'b1;
                if (t2_count <= ticks)
                    ifr[FLAG_T2_BIT] = 1'b1;
                t1_count = t1_count - ticks;
                t2_count = t2_count - ticks;
                res.irq_out = (ifr[FLAG_T1_BIT] & ier[FLAG_T1_BIT])
                            | (ifr[FLAG_T2_BIT] & ier[FLAG_T2_BIT]);
            end
            default: ;  // unused request type: no effect, zero result
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_b    = '0;
            port_a    = '0;
            ddr_b     = '0;
            ddr_a     = '0;
            t1_count  = '0;
            t1_latch  = '0;
            t2_count  = '0;
            t2_latch  = '0;
            shift_val = '0;
            acr       = '0;
            pcr       = '0;
            ifr       = '0;
            ier       = '0;
            expected_results.delete();
            expected_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                bus_access(req_type, reg_offset, write_data, tick_count, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word: read_data %02h irq_out %0b",
                             $time, read_data, irq_out);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (read_data !== oldest.read_data)
                    begin
                        mismatch_count++;
                        $display("%0t: read_data expected %02h, got %02h",
                                 $time, oldest.read_data, read_data);
                    end
                    if (irq_out !== oldest.irq_out)
                    begin
                        mismatch_count++;
                        $display("%0t: irq_out expected %0b, got %0b",
                                 $time, oldest.irq_out, irq_out);
                    end
                end
            end
            expected_count = expected_results.size();
        end
    end

endmodule

@@ tb/via_timer_register_block_top_test.sv @@
// ----------------------------------------------------------------------------
// via_timer_register_block_top_test
// Drives the VIA timer/register block with a short directed sequence and
// then random bus reads, writes and timer ticks. Sender gaps and receiver
// stalls change from phase to phase. Checking is done in the checker module.
// ----------------------------------------------------------------------------
module via_timer_register_block_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import via_tmr_pkg::*;

    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          PHASE_WORDS      = 475;
    localparam logic [1:0]  REQ_UNUSED       = 2'd3;
    localparam logic [3:0]  REG_PORT_A_ALIAS = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  reg_offset;
    logic [7:0]  write_data;
    logic [15:0] tick_count;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        irq_out;

    int          mismatch_count;
    int          expected_count;
    int          idle_pct;
    int          stall_pct;
    int          cycle_count = 0;

    via_timer_register_block_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .tick_count (tick_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .irq_out    (irq_out)
    );

    via_timer_register_block_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .reg_offset  (reg_offset),
        .write_data  (write_data),
        .tick_count  (tick_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .irq_out     (irq_out),
        .mismatches  (mismatch_count),
        .outstanding (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_stall   <= ($urandom_range(99, 0) < stall_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Optional idle gap, then hold the word until it is taken.
    task automatic send_word(input logic [1:0] kind, input logic [3:0] idx,
                             input logic [7:0] data, input logic [15:0] ticks);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid   <= 1'b0;
            req_type   <= 2'($urandom);
            reg_offset <= 4'($urandom);
            write_data <= 8'($urandom);
            tick_count <= 16'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        reg_offset <= idx;
        write_data <= data;
        tick_count <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int          left;
        int          pick;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] ticks;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(99, 0) < 8)
            begin
                // short timers, random enables, then ticks toward zero and an IFR read
                send_word(REQ_WRITE, REG_T1_LO, 8'($urandom_range(0, 40)), 16'($urandom));
                send_word(REQ_WRITE, REG_T1_HI, 8'($urandom_range(0, 1)), 16'($urandom));
                send_word(REQ_WRITE, REG_T2_LO, 8'($urandom), 16'($urandom));
                send_word(REQ_WRITE, REG_T2_HI, 8'($urandom_range(0, 1)), 16'($urandom));
                send_word(REQ_WRITE, REG_IER, 8'($urandom), 16'($urandom));
                repeat (3)
                    send_word(REQ_TICK, 4'($urandom), 8'($urandom),
                              16'($urandom_range(0, 64)));
                send_word(REQ_READ, REG_IFR, 8'($urandom), 16'($urandom));
                left -= 9;
            end
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < 35)
                    kind = REQ_READ;
                else if (pick < 70)
                    kind = REQ_WRITE;
                else if (pick < 96)
                    kind = REQ_TICK;
                else
                    kind = REQ_UNUSED;

                pick = $urandom_range(99, 0);
                if (pick < 30)
                    data = 8'h00;
                else if (pick < 40)
                    data = 8'hFF;
                else
                    data = 8'($urandom);

                pick = $urandom_range(99, 0);
                if (pick < 10)
                    ticks = 16'h0000;
                else if (pick < 17)
                    ticks = 16'hFFFF;
                else if (pick < 55)
                    ticks = 16'($urandom_range(0, 15));
                else if (pick < 75)
                    ticks = 16'($urandom_range(0, 1023));
                else
                    ticks = 16'($urandom);

                send_word(kind, 4'($urandom), data, ticks);
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = '0;
        reg_offset = '0;
        write_data = '0;
        tick_count = '0;
        out_stall  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // enable register set and clear through bit 7
        send_word(REQ_WRITE, REG_IER, 8'hFF, 16'h0000);
        send_word(REQ_READ,  REG_IER, 8'h00, 16'h0000);
        send_word(REQ_WRITE, REG_IER, 8'h7F, 16'h0000);
        send_word(REQ_READ,  REG_IER, 8'h00, 16'h0000);
        send_word(REQ_WRITE, REG_IER, 8'hE0, 16'h0000);
        // T1 = 3, T2 = 2
        send_word(REQ_WRITE, REG_T1_LO, 8'h03, 16'h0000);
        send_word(REQ_WRITE, REG_T1_HI, 8'h00, 16'h0000);
        send_word(REQ_WRITE, REG_T2_LO, 8'h02, 16'h0000);
        send_word(REQ_WRITE, REG_T2_HI, 8'h00, 16'h0000);
        // zero tick, T2 reaching zero, zero tick on a counter at zero
        send_word(REQ_TICK,  REG_PORT_B, 8'h00, 16'h0000);
        send_word(REQ_TICK,  REG_PORT_B, 8'h00, 16'h0002);
        send_word(REQ_TICK,  REG_PORT_B, 8'h00, 16'h0000);
        send_word(REQ_READ,  REG_IFR, 8'h00, 16'h0000);
        // T1 high read drops the T1 flag
        send_word(REQ_READ,  REG_T1_HI, 8'h00, 16'h0000);
        send_word(REQ_READ,  REG_IFR, 8'h00, 16'h0000);
        send_word(REQ_TICK,  REG_PORT_A_ALIAS, 8'hFF, 16'hFFFF);
        send_word(REQ_WRITE, REG_IFR, 8'hFF, 16'hFFFF);
        // timer enables cleared, non-timer flags and enables set: irq stays low
        send_word(REQ_WRITE, REG_IER, 8'h60, 16'h0000);
        send_word(REQ_WRITE, REG_IER, 8'h9F, 16'h0000);
        send_word(REQ_WRITE, REG_IFR, 8'h1F, 16'h0000);
        send_word(REQ_TICK,  REG_PORT_B, 8'h00, 16'h0001);
        send_word(REQ_WRITE, REG_PORT_A_ALIAS, 8'hA5, 16'h0000);
        send_word(REQ_READ,  REG_PORT_A, 8'h00, 16'h0000);
        send_word(REQ_UNUSED, REG_PORT_A_ALIAS, 8'hFF, 16'hFFFF);
        send_word(REQ_READ,  REG_PORT_A_ALIAS, 8'h00, 16'h0000);

        run_random(PHASE_WORDS);
        idle_pct  = 84;
        run_random(PHASE_WORDS);
        idle_pct  = 0;
        stall_pct = 84;
        run_random(PHASE_WORDS);
        idle_pct  = 29;
        stall_pct = 29;
        run_random(PHASE_WORDS);

        in_valid <= 1'b0;
        stall_pct = 0;
        do
            @(posedge clk);
        while (expected_count != 0);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0 && expected_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/via_tmr_pkg.sv
rtl/core/via_tmr_regs.sv
rtl/core/via_timer_register_block_top.sv
tb/via_timer_register_block_checker.sv
tb/via_timer_register_block_top_test.sv
